// File: hw/rtl/gaps_pkg.sv
// Shared types, codes and default sizes for the glyph atlas packer and stroker.
package gaps_pkg;

    localparam int ATLAS_SIDE_DEF     = 512;
    localparam int MAX_STROKE_DEF     = 3;
    localparam int MAX_GLYPH_SIDE_DEF = 255;

    localparam logic [1:0] MODE_BEGIN = 2'd0;
    localparam logic [1:0] MODE_PIXEL = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [7:0] COLOR_FULL = 8'd255;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] glyph_width;
        logic [7:0] glyph_height;
        logic [7:0] pixel_value;
        logic [8:0] read_x;
        logic [8:0] read_y;
    } t_item;

    typedef struct packed {
        logic [8:0] cell_x;
        logic [9:0] cell_y;
        logic [8:0] cell_width;
        logic [8:0] cell_height;
        logic       out_of_space;
        logic [7:0] color_value;
        logic [7:0] alpha_value;
    } t_result;

    typedef struct packed {
        logic latch;
        logic clear_step;
        logic begin_calc;
        logic place;
        logic pix_setup;
        logic plain;
        logic dil_step;
        logic advance;
        logic read_issue;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic pix_ignore;
        logic pix_simple;
        logic dil_last;
    } t_stat;

endpackage

// File: hw/rtl/glyph_atlas_packer_stroker.sv
// Top level of the shelf-packing glyph atlas writer with outline dilation.
//
//  channel   direction  transfer when                 payload
//  command   in         start && !busy                i_item   (gaps_pkg::t_item)
//  result    out        o_strobe (one cycle)          o_result (gaps_pkg::t_result)
//  config    in         i_cfg_valid && o_cfg_ready    i_cfg_data (stroke radius)
//
// After reset the atlas memory is cleared one entry per cycle, all ATLAS_SIDE*ATLAS_SIDE
// entries; busy stays high until that ends.
// Steps per item: mode 3 only finishes, a read issues its read, a begin decides the wrap
// and then places, an ignored pixel only checks, a plain pixel does one write step, and a
// stroked nonzero pixel does one read-modify-write per neighbor in the square of radius s
// on the single atlas memory port pair. The result strobe comes in the cycle busy drops.
// Results cannot be held off; config writes are taken at any time.
module glyph_atlas_packer_stroker #(
    parameter int ATLAS_SIDE     = gaps_pkg::ATLAS_SIDE_DEF,
    parameter int MAX_STROKE     = gaps_pkg::MAX_STROKE_DEF,
    parameter int MAX_GLYPH_SIDE = gaps_pkg::MAX_GLYPH_SIDE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  gaps_pkg::t_item    i_item,
    output gaps_pkg::t_result  o_result,
    output logic               o_strobe,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_data
);

    gaps_pkg::t_cmd  cmd;
    gaps_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    gaps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_item.mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    gaps_dp #(
        .ATLAS_SIDE     (ATLAS_SIDE),
        .MAX_STROKE     (MAX_STROKE),
        .MAX_GLYPH_SIDE (MAX_GLYPH_SIDE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_result   (o_result),
        .o_strobe   (o_strobe)
    );

endmodule

// File: hw/rtl/gaps_ctrl.sv
// Sequencer that steps the datapath through clearing, packing, pixel and read work.
module gaps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_mode,
    input  gaps_pkg::t_stat  i_stat,
    output gaps_pkg::t_cmd   o_cmd,
    output logic             o_busy
);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_BEGIN  = 10'b00_0000_0100,
        S_PLACE  = 10'b00_0000_1000,
        S_PIX    = 10'b00_0001_0000,
        S_PLAIN  = 10'b00_0010_0000,
        S_DIL    = 10'b00_0100_0000,
        S_DRAIN  = 10'b00_1000_0000,
        S_RD     = 10'b01_0000_0000,
        S_FINISH = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    case (i_mode)
                        gaps_pkg::MODE_BEGIN: n_state = S_BEGIN;
                        gaps_pkg::MODE_PIXEL: n_state = S_PIX;
                        gaps_pkg::MODE_READ:  n_state = S_RD;
                        default:              n_state = S_FINISH;
                    endcase
                end
            end
            S_BEGIN: begin
                o_cmd.begin_calc = 1'b1;
                n_state = S_PLACE;
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state = S_FINISH;
            end
            S_PIX: begin
                if (i_stat.pix_ignore) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.pix_setup = 1'b1;
                    n_state = i_stat.pix_simple ? S_PLAIN : S_DIL;
                end
            end
            S_PLAIN: begin
                o_cmd.plain   = 1'b1;
                o_cmd.advance = 1'b1;
                n_state = S_FINISH;
            end
            S_DIL: begin
                o_cmd.dil_step = 1'b1;
                if (i_stat.dil_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last read-modify-write lands in this cycle.
                o_cmd.advance = 1'b1;
                n_state = S_FINISH;
            end
            S_RD: begin
                o_cmd.read_issue = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: hw/rtl/gaps_dp.sv
// Packing registers, pixel counters, dilation address walk and the atlas memory.
module gaps_dp #(
    parameter int ATLAS_SIDE     = gaps_pkg::ATLAS_SIDE_DEF,
    parameter int MAX_STROKE     = gaps_pkg::MAX_STROKE_DEF,
    parameter int MAX_GLYPH_SIDE = gaps_pkg::MAX_GLYPH_SIDE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gaps_pkg::t_item    i_item,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data,
    input  gaps_pkg::t_cmd     i_cmd,
    output gaps_pkg::t_stat    o_stat,
    output gaps_pkg::t_result  o_result,
    output logic               o_strobe
);

    // Coordinates carry headroom for cells wider than a small atlas.
    localparam int CW    = $clog2(ATLAS_SIDE) + 4;
    localparam int DEPTH = ATLAS_SIDE * ATLAS_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CW-1:0] SIDE_C = CW'(ATLAS_SIDE);
    localparam logic [AW-1:0] SIDE_A = AW'(ATLAS_SIDE);
    localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

    typedef struct packed {
        logic [7:0] color;
        logic [7:0] alpha;
    } t_texel;

    t_texel r_atlas [DEPTH];
    t_texel r_rdata;

    logic [1:0]      r_stroke;
    logic [1:0]      s;
    logic [2:0]      s2;

    gaps_pkg::t_item r_item;
    logic [7:0]      r_gw, r_gh;
    logic [8:0]      r_w, r_h;
    logic [7:0]      gw_sat, gh_sat;

    logic [CW-1:0]   r_pack_x, r_pack_y, r_org_x, r_org_y;
    logic [8:0]      r_shelf;
    logic [7:0]      r_size_w, r_size_h, r_col, r_row;
    logic            r_exh;

    logic            r_wrap;
    logic [CW-1:0]   r_ny;
    logic [8:0]      r_shelf_max;
    logic [8:0]      shelf_max;
    logic [CW-1:0]   px, py;
    logic            fit_fail;

    logic            r_placed;
    logic [8:0]      r_cell_x, r_cell_w, r_cell_h;
    logic [9:0]      r_cell_y;

    logic [CW:0]     r_x, r_y, r_bx;
    logic [2:0]      r_dx, r_dy;
    logic [CW-1:0]   tx, ty;

    logic [CW:0]     sel_x, sel_y;
    logic            sel_in;
    logic [AW-1:0]   gen_addr;

    logic            r_rmw_valid, r_rmw_in, r_rmw_center;
    logic [AW-1:0]   r_wr_addr;
    logic            r_rd_in;
    logic [AW-1:0]   r_clr_addr;

    logic            we;
    logic [AW-1:0]   wa;
    t_texel          wd;

    gaps_pkg::t_result r_result, n_result;
    logic              r_strobe;

    always_comb begin
        s  = (32'(r_stroke) > MAX_STROKE) ? 2'(MAX_STROKE) : r_stroke;
        s2 = {s, 1'b0};
        gw_sat = (32'(i_item.glyph_width) > MAX_GLYPH_SIDE) ?
                 8'(MAX_GLYPH_SIDE) : i_item.glyph_width;
        gh_sat = (32'(i_item.glyph_height) > MAX_GLYPH_SIDE) ?
                 8'(MAX_GLYPH_SIDE) : i_item.glyph_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stroke <= '0;
        end else if (i_cfg_we) begin
            r_stroke <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
            r_gw   <= gw_sat;
            r_gh   <= gh_sat;
            r_w    <= 9'(gw_sat) + 9'(s2) + 9'd1;
            r_h    <= 9'(gh_sat) + 9'(s2) + 9'd1;
        end
    end

    // Shelf packing: the begin_calc step decides the wrap, then the place step places.
    always_comb begin
        shelf_max = (r_h > r_shelf) ? r_h : r_shelf;
        px        = r_wrap ? '0 : r_pack_x;
        py        = r_wrap ? r_ny : r_pack_y;
        fit_fail  = (r_ny + CW'(r_h)) >= SIDE_C;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.begin_calc) begin
            r_wrap      <= (r_pack_x + CW'(r_w)) >= SIDE_C;
            r_ny        <= r_pack_y + CW'(shelf_max);
            r_shelf_max <= shelf_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack_x <= '0;
            r_pack_y <= '0;
            r_shelf  <= '0;
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_size_w <= '0;
            r_size_h <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_exh    <= 1'b0;
            r_placed <= 1'b0;
        end else if (i_cmd.latch) begin
            r_placed <= 1'b0;
        end else if (i_cmd.place) begin
            r_col    <= '0;
            r_row    <= '0;
            if (!r_exh) begin
                if (r_wrap && fit_fail) begin
                    r_pack_x <= '0;
                    r_pack_y <= r_ny;
                    r_shelf  <= r_h;
                    r_exh    <= 1'b1;
                    r_size_w <= '0;
                    r_size_h <= '0;
                end else begin
                    r_shelf  <= r_wrap ? r_h : r_shelf_max;
                    r_pack_y <= py;
                    r_pack_x <= px + CW'(r_w);
                    r_org_x  <= px + CW'(s);
                    r_org_y  <= py + CW'(s);
                    r_size_w <= r_gw;
                    r_size_h <= r_gh;
                    r_placed <= 1'b1;
                end
            end else begin
                r_size_w <= '0;
                r_size_h <= '0;
            end
        end else if (i_cmd.advance) begin
            if ((9'(r_col) + 9'd1) >= 9'(r_size_w)) begin
                r_col <= '0;
                r_row <= r_row + 8'd1;
            end else begin
                r_col <= r_col + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.place) begin
            r_cell_x <= px[8:0];
            r_cell_y <= py[9:0];
            r_cell_w <= 9'(r_gw) + 9'(s2);
            r_cell_h <= 9'(r_gh) + 9'(s2);
        end
    end

    // Neighborhood walk; positions that fall left of or above the atlas go negative.
    assign tx = r_org_x + CW'(r_col);
    assign ty = r_org_y + CW'(r_row);

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_setup) begin
            r_x  <= {1'b0, tx} - (CW+1)'(s);
            r_bx <= {1'b0, tx} - (CW+1)'(s);
            r_y  <= {1'b0, ty} - (CW+1)'(s);
            r_dx <= '0;
            r_dy <= '0;
        end else if (i_cmd.dil_step) begin
            if (r_dx == s2) begin
                r_dx <= '0;
                r_x  <= r_bx;
                r_dy <= r_dy + 3'd1;
                r_y  <= r_y + (CW+1)'(1);
            end else begin
                r_dx <= r_dx + 3'd1;
                r_x  <= r_x + (CW+1)'(1);
            end
        end
    end

    always_comb begin
        sel_x = i_cmd.read_issue ? (CW+1)'(r_item.read_x) : r_x;
        sel_y = i_cmd.read_issue ? (CW+1)'(r_item.read_y) : r_y;
        sel_in = !sel_x[CW] && (sel_x[CW-1:0] < SIDE_C) &&
                 !sel_y[CW] && (sel_y[CW-1:0] < SIDE_C);
        gen_addr = AW'(sel_y[CW-1:0]) * SIDE_A + AW'(sel_x[CW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rmw_valid <= 1'b0;
            r_clr_addr  <= '0;
        end else begin
            r_rmw_valid <= i_cmd.dil_step;
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dil_step) begin
            r_rmw_in     <= sel_in;
            r_rmw_center <= (r_dx == 3'(s)) && (r_dy == 3'(s));
            r_wr_addr    <= gen_addr;
        end
        if (i_cmd.read_issue) begin
            r_rd_in <= sel_in;
        end
    end

    // Write port: clearing sweep, plain copy, or the write half of a dilation step.
    always_comb begin
        we = 1'b0;
        wa = gen_addr;
        wd = '0;
        if (i_cmd.clear_step) begin
            we = 1'b1;
            wa = r_clr_addr;
        end else if (i_cmd.plain) begin
            we = (s == 2'd0) && sel_in;
            wd.color = gaps_pkg::COLOR_FULL;
            wd.alpha = r_item.pixel_value;
        end else if (r_rmw_valid) begin
            we = r_rmw_in;
            wa = r_wr_addr;
            wd.color = r_rdata.color + (r_rmw_center ? r_item.pixel_value : 8'd0);
            wd.alpha = (r_item.pixel_value > r_rdata.alpha) ?
                       r_item.pixel_value : r_rdata.alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_atlas[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_issue || i_cmd.dil_step) begin
            r_rdata <= r_atlas[gen_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.finish;
        end
    end

    always_comb begin
        n_result              = '0;
        n_result.out_of_space = r_exh;
        if (r_item.mode == gaps_pkg::MODE_BEGIN && r_placed) begin
            n_result.cell_x      = r_cell_x;
            n_result.cell_y      = r_cell_y;
            n_result.cell_width  = r_cell_w;
            n_result.cell_height = r_cell_h;
        end
        if (r_item.mode == gaps_pkg::MODE_READ && r_rd_in) begin
            n_result.color_value = r_rdata.color;
            n_result.alpha_value = r_rdata.alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result <= n_result;
        end
    end

    always_comb begin
        o_stat.clr_last   = (r_clr_addr == LAST_A);
        o_stat.pix_ignore = r_exh || (r_size_w == 8'd0) || (r_row >= r_size_h);
        o_stat.pix_simple = (s == 2'd0) || (r_item.pixel_value == 8'd0);
        o_stat.dil_last   = (r_dx == s2) && (r_dy == s2);
    end

    assign o_result = r_result;
    assign o_strobe = r_strobe;

endmodule

// File: bench/glyph_atlas_packer_stroker_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the glyph atlas packer: shelf placement, pixel writes and reads.
module glyph_atlas_packer_stroker_tb;
    import gaps_pkg::*;

    localparam int SIDE           = ATLAS_SIDE_DEF;
    localparam int ATLAS_PIX      = SIDE * SIDE;
    // The clearing pass after reset covers all ATLAS_PIX entries with nothing transferred.
    localparam int WATCHDOG_LIMIT = 800_000;
    localparam int TAIL_CYCLES    = 64;
    localparam logic [1:0] MODE_NONE = 2'd3;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    t_item      i_item      = '0;
    logic       i_cfg_valid = 1'b0;
    logic [1:0] i_cfg_data  = 2'd0;
    logic       busy;
    logic       o_strobe;
    logic       o_cfg_ready;
    t_result    o_result;

    glyph_atlas_packer_stroker u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_result    (o_result),
        .o_strobe    (o_strobe),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the atlas and the packer state.
    bit [7:0] shadow_color [ATLAS_PIX];
    bit [7:0] shadow_alpha [ATLAS_PIX];
    bit [9:0] shelf_x, shelf_y;
    bit [8:0] shelf_tall;
    bit [9:0] org_x, org_y;
    bit [7:0] gly_w, gly_h, col_ptr, row_ptr;
    bit       full_flag;
    bit [1:0] stroke_reg;
    bit [9:0] last_cx, last_cy;
    bit [8:0] last_cw, last_ch;

    t_result atlas_results_due[$];
    int      mismatch_count = 0;
    int      idle_cycles    = 0;
    bit      no_idle        = 1'b0;

    function automatic int unsigned atlas_index(input int unsigned x, input int unsigned y);
        return x + y * SIDE;
    endfunction

    function automatic void place_glyph(input bit [7:0] gw, input bit [7:0] gh,
                                        inout t_result r);
        int unsigned s, w, h;
        s = 32'(stroke_reg);
        w = 32'(gw) + 2 * s + 1;
        h = 32'(gh) + 2 * s + 1;
        gly_w   = '0;
        gly_h   = '0;
        col_ptr = '0;
        row_ptr = '0;
        if (full_flag) return;
        if (h > 32'(shelf_tall)) shelf_tall = 9'(h);
        if (32'(shelf_x) + w >= SIDE) begin
            shelf_x    = '0;
            shelf_y    = shelf_y + 10'(shelf_tall);
            shelf_tall = 9'(h);
            if (32'(shelf_y) + h >= SIDE) begin
                full_flag = 1'b1;
                return;
            end
        end
        org_x = shelf_x + 10'(s);
        org_y = shelf_y + 10'(s);
        gly_w = gw;
        gly_h = gh;
        r.cell_x      = shelf_x[8:0];
        r.cell_y      = shelf_y;
        r.cell_width  = 9'(32'(gw) + 2 * s);
        r.cell_height = 9'(32'(gh) + 2 * s);
        last_cx = shelf_x;
        last_cy = shelf_y;
        last_cw = r.cell_width;
        last_ch = r.cell_height;
        shelf_x = shelf_x + 10'(w);
    endfunction

    function automatic void write_glyph_pixel(input bit [7:0] pix);
        int unsigned s, tx, ty, x, y, dx, dy, a;
        if (full_flag || gly_w == 8'd0 || row_ptr >= gly_h) return;
        s  = 32'(stroke_reg);
        tx = 32'(org_x) + 32'(col_ptr);
        ty = 32'(org_y) + 32'(row_ptr);
        if (s == 0) begin
            if (tx < SIDE && ty < SIDE) begin
                a = atlas_index(tx, ty);
                shadow_color[a] = COLOR_FULL;
                shadow_alpha[a] = pix;
            end
        end else begin
            if (pix != 8'd0) begin
                // A stroke raised mid-glyph can wrap below zero; such writes fall outside.
                for (dy = 0; dy <= 2 * s; dy++) begin
                    for (dx = 0; dx <= 2 * s; dx++) begin
                        x = tx + dx - s;
                        y = ty + dy - s;
                        if (x < SIDE && y < SIDE) begin
                            a = atlas_index(x, y);
                            if (pix > shadow_alpha[a]) shadow_alpha[a] = pix;
                        end
                    end
                end
            end
            if (tx < SIDE && ty < SIDE) begin
                a = atlas_index(tx, ty);
                shadow_color[a] = shadow_color[a] + pix;
            end
        end
        col_ptr = col_ptr + 8'd1;
        if (col_ptr >= gly_w) begin
            col_ptr = '0;
            row_ptr = row_ptr + 8'd1;
        end
    endfunction

    function automatic t_result predict_atlas_result(input t_item it);
        t_result r;
        r = '0;
        case (it.mode)
            MODE_BEGIN: place_glyph(it.glyph_width, it.glyph_height, r);
            MODE_PIXEL: write_glyph_pixel(it.pixel_value);
            MODE_READ: begin
                // Nine-bit coordinates always fall inside the atlas.
                r.color_value = shadow_color[atlas_index(32'(it.read_x), 32'(it.read_y))];
                r.alpha_value = shadow_alpha[atlas_index(32'(it.read_x), 32'(it.read_y))];
            end
            default: ;
        endcase
        r.out_of_space = full_flag;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 100) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (atlas_results_due.size() == 0) begin
                report_mismatch("result with no item outstanding");
            end else begin
                want = atlas_results_due.pop_front();
                check_field("cell_x", 16'(o_result.cell_x), 16'(want.cell_x));
                check_field("cell_y", 16'(o_result.cell_y), 16'(want.cell_y));
                check_field("cell_width", 16'(o_result.cell_width), 16'(want.cell_width));
                check_field("cell_height", 16'(o_result.cell_height),
                            16'(want.cell_height));
                check_field("out_of_space", 16'(o_result.out_of_space),
                            16'(want.out_of_space));
                check_field("color_value", 16'(o_result.color_value),
                            16'(want.color_value));
                check_field("alpha_value", 16'(o_result.alpha_value),
                            16'(want.alpha_value));
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_coverage();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 8'd0;
        if (r < 5) return 8'd255;
        return 8'($urandom_range(1, 254));
    endfunction

    // Unused fields carry random content so that every bit gets exercised.
    function automatic t_item noise_item(input logic [1:0] mode);
        t_item it;
        it.mode         = mode;
        it.glyph_width  = 8'($urandom_range(0, 255));
        it.glyph_height = 8'($urandom_range(0, 255));
        it.pixel_value  = 8'($urandom_range(0, 255));
        it.read_x       = 9'($urandom_range(0, 511));
        it.read_y       = 9'($urandom_range(0, 511));
        return it;
    endfunction

    // Start stays high between back-to-back items; it is lowered only for a gap or while results drain.
    task automatic send_item(input t_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        atlas_results_due = {atlas_results_due, predict_atlas_result(it)};
    endtask

    task automatic send_begin(input logic [7:0] w, input logic [7:0] h);
        t_item it;
        it = noise_item(MODE_BEGIN);
        it.glyph_width  = w;
        it.glyph_height = h;
        send_item(it);
    endtask

    task automatic send_pixel(input logic [7:0] v);
        t_item it;
        it = noise_item(MODE_PIXEL);
        it.pixel_value = v;
        send_item(it);
    endtask

    task automatic send_read(input logic [8:0] x, input logic [8:0] y);
        t_item it;
        it = noise_item(MODE_READ);
        it.read_x = x;
        it.read_y = y;
        send_item(it);
    endtask

    task automatic send_read_near_cell();
        int x, y;
        x = 32'(last_cx) + $urandom_range(0, 32'(last_cw));
        y = 32'(last_cy) + $urandom_range(0, 32'(last_ch));
        send_read(x[8:0], y[8:0]);
    endtask

    task automatic wait_results_drained();
        if (start) start <= 1'b0;
        while (atlas_results_due.size() != 0) @(posedge i_clk);
    endtask

    // Every item yields a result, so the block is idle once the queue is empty.
    task automatic write_stroke(input logic [1:0] radius);
        wait_results_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= radius;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        stroke_reg = radius;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_idle_atlas();
        send_pixel(8'd255);
        send_read(9'd0, 9'd0);
        send_read(9'd511, 9'd511);
        send_item(noise_item(MODE_NONE));
    endtask

    task automatic test_plain_copy();
        write_stroke(2'd0);
        send_begin(8'd3, 8'd2);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd1);
        send_pixel(8'd128);
        send_pixel(8'd77);
        send_pixel(8'd200);
        // One past the last row: ignored.
        send_pixel(8'd9);
        send_read(last_cx[8:0], last_cy[8:0]);
        send_read(9'(last_cx + 2), 9'(last_cy + 1));
    endtask

    task automatic test_stroke_dilation();
        write_stroke(2'd3);
        send_begin(8'd2, 8'd2);
        send_pixel(8'd40);
        send_pixel(8'd0);
        send_pixel(8'd200);
        send_pixel(8'd7);
        send_read(last_cx[8:0], last_cy[8:0]);
        send_read(9'(last_cx + 4), 9'(last_cy + 4));
    endtask

    task automatic test_glyph_restart();
        send_begin(8'd4, 8'd4);
        send_pixel(8'd9);
        send_pixel(8'd10);
        send_begin(8'd0, 8'd0);
        send_pixel(8'd5);
        send_begin(8'd255, 8'd0);
        send_pixel(8'd5);
    endtask

    // Place a plain glyph that ends two columns short of the right edge, then widen the stroke so
    // that dilation of its last column spills past the atlas.
    task automatic test_stroke_change_at_edge();
        write_stroke(2'd0);
        while (!full_flag && (shelf_x < 256 || shelf_x > 500)) send_begin(8'd255, 8'd1);
        if (!full_flag && shelf_x < 500) send_begin(8'(499 - 32'(shelf_x)), 8'd0);
        send_begin(8'd10, 8'd1);
        repeat (5) send_pixel(pick_coverage());
        write_stroke(2'd3);
        repeat (5) send_pixel(8'($urandom_range(1, 255)));
        send_read(9'd511, 9'(last_cy + 1));
    endtask

    task automatic run_random_glyphs(input int n_items, input bit restroke);
        int sent, w, h, npix, cut, k, r;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 3) != 0) begin
                r = $urandom_range(0, 19);
                if (r < 16) begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(1, 8);
                end else if (r < 19) begin
                    w = $urandom_range(9, 24);
                    h = $urandom_range(1, 10);
                end else begin
                    w = $urandom_range(100, 255);
                    h = $urandom_range(1, 2);
                end
                send_begin(8'(w), 8'(h));
                sent++;
                npix = w * h;
                cut  = npix;
                if ($urandom_range(0, 4) == 0) cut = $urandom_range(0, npix);
                if (cut > 60) cut = 60;
                for (k = 0; k < cut; k++) begin
                    if (restroke && $urandom_range(0, 39) == 0)
                        write_stroke(2'($urandom_range(0, 3)));
                    send_pixel(pick_coverage());
                    sent++;
                    if ($urandom_range(0, 6) == 0) begin
                        send_read_near_cell();
                        sent++;
                    end
                end
                if (cut == npix && $urandom_range(0, 3) == 0) send_pixel(pick_coverage());
                if ($urandom_range(0, 9) == 0) wait_results_drained();
            end else begin
                case ($urandom_range(0, 3))
                    0: send_item(noise_item(MODE_NONE));
                    1: begin
                        send_read(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
                        sent++;
                    end
                    2: begin
                        send_pixel(pick_coverage());
                        sent++;
                    end
                    default: begin
                        if ($urandom_range(0, 9) == 0)
                            send_begin(8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 10)));
                        else
                            send_begin(8'($urandom_range(0, 40)),
                                       8'($urandom_range(0, 10)));
                        sent++;
                    end
                endcase
            end
        end
    endtask

    task automatic test_random_traffic();
        write_stroke(2'd0);
        run_random_glyphs(200, 1'b0);
        write_stroke(2'd3);
        run_random_glyphs(220, 1'b0);
        write_stroke(2'd1);
        no_idle = 1'b1;
        run_random_glyphs(150, 1'b0);
        no_idle = 1'b0;
        write_stroke(2'd2);
        run_random_glyphs(200, 1'b1);
    endtask

    // Fill shelves down to the bottom, place a tall glyph whose lower rows fall
    // outside, then run out of space and check that only reads still work.
    task automatic test_out_of_space();
        write_stroke(2'd3);
        while (!full_flag && shelf_y < 447) send_begin(8'd255, 8'd20);
        send_begin(8'd1, 8'd80);
        repeat (80) send_pixel(8'($urandom_range(1, 255)));
        send_read(9'(last_cx + 3), 9'd511);
        send_read(9'(last_cx + 4), 9'd508);
        send_begin(8'd255, 8'd255);
        send_begin(8'd1, 8'd1);
        send_pixel(8'd50);
        send_read(9'(last_cx + 3), 9'(last_cy + 10));
        send_item(noise_item(MODE_NONE));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_atlas();
        test_plain_copy();
        test_stroke_dilation();
        test_glyph_restart();
        test_stroke_change_at_edge();
        test_random_traffic();
        test_out_of_space();
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
